// ===== sv/scl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_pkg
// Shared types and constants of the command line lexer.
// ----------------------------------------------------------------------------
package scl_pkg;

  localparam int RES_MAX   = 4;
  localparam int RES_IDX_W = 2;
  localparam int RES_CNT_W = 3;
  localparam int CNT_W     = 10;
  localparam int LEN_W     = 8;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_GT  = 8'h3e;
  localparam logic [7:0] CH_LT  = 8'h3c;
  localparam logic [7:0] CH_BAR = 8'h7c;

  typedef enum logic [2:0] {
    KIND_BYTE = 3'd0,
    KIND_WEND = 3'd1,
    KIND_ROUT = 3'd2,
    KIND_RIN  = 3'd3,
    KIND_APP  = 3'd4,
    KIND_PIPE = 3'd5,
    KIND_LEND = 3'd6
  } kind_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [RES_CNT_W-1:0]      n;
    kind_t [RES_MAX-1:0]       kinds;
    logic [7:0]                word_byte;
    logic [CNT_W-1:0]          total;
  } bundle_t;

endpackage

// ===== sv/scl_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_cmd_if
// Input byte channel of the command line lexer.
// ----------------------------------------------------------------------------
interface scl_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       line_end;

  modport source(output valid, output char_in, output line_end, input ready);
  modport sink(input valid, input char_in, input line_end, output ready);
endinterface

// ===== sv/scl_tok_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_tok_if
// Token result channel of the command line lexer.
// ----------------------------------------------------------------------------
interface scl_tok_if;
  logic                          valid;
  logic                          ready;
  scl_pkg::kind_t                kind;
  logic [7:0]                    word_byte;
  logic [scl_pkg::CNT_W-1:0]     token_total;
  logic                          last_of_run;

  modport source(output valid, output kind, output word_byte, output token_total,
                 output last_of_run, input ready);
  modport sink(input valid, input kind, input word_byte, input token_total,
               input last_of_run, output ready);
endinterface

// ===== sv/scl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_front
// Classifies each input byte, updates the lexer state and builds the bundle
// of results that the byte causes.
// ----------------------------------------------------------------------------
module scl_front #(
  parameter int MAX_WORD = 255
) (
  input  logic               clk,
  input  logic               rst,
  scl_cmd_if.sink            cmd,
  output logic               push,
  output scl_pkg::bundle_t   push_data,
  input  logic               full
);

  typedef struct packed {
    logic                                  iw;
    logic                                  q;
    logic                                  qd;
    logic                                  pg;
    logic [scl_pkg::LEN_W-1:0]             wl;
    logic [scl_pkg::CNT_W-1:0]             cnt;
    logic [scl_pkg::RES_CNT_W-1:0]         n;
    scl_pkg::kind_t [scl_pkg::RES_MAX-1:0] kinds;
  } work_t;

  logic                      in_word;
  logic                      quoting;
  logic                      quote_is_double;
  logic                      pending_greater;
  logic [scl_pkg::LEN_W-1:0] word_length;
  logic [scl_pkg::CNT_W-1:0] token_counter;

  logic                      accept;
  work_t                     w;
  logic [7:0]                wb;
  logic [scl_pkg::CNT_W-1:0] total;

  function automatic work_t emit(work_t s, scl_pkg::kind_t k);
    work_t r;
    r = s;
    if (r.n < scl_pkg::RES_CNT_W'(scl_pkg::RES_MAX)) begin
      r.kinds[r.n[scl_pkg::RES_IDX_W-1:0]] = k;
      r.n = r.n + 1'b1;
    end
    return r;
  endfunction

  function automatic work_t count(work_t s);
    work_t r;
    r = s;
    if (r.cnt < scl_pkg::COUNT_MAX) r.cnt = r.cnt + 1'b1;
    return r;
  endfunction

  function automatic work_t close_word(work_t s);
    work_t r;
    r = s;
    if (r.iw && r.wl != '0) begin
      r = emit(r, scl_pkg::KIND_WEND);
      r = count(r);
    end
    r.iw = 1'b0;
    r.q  = 1'b0;
    r.qd = 1'b0;
    r.wl = '0;
    return r;
  endfunction

  assign cmd.ready = !full && !rst;
  assign accept    = cmd.valid && cmd.ready;

  always_comb begin
    logic [7:0]     c;
    logic           take;
    logic           as_byte;
    logic           cw;
    logic           has_op;
    scl_pkg::kind_t op;
    c       = cmd.char_in;
    take    = 1'b1;
    as_byte = 1'b0;
    cw      = 1'b0;
    has_op  = 1'b0;
    op      = scl_pkg::KIND_PIPE;
    wb      = '0;
    total   = '0;
    w       = '0;
    w.iw    = in_word;
    w.q     = quoting;
    w.qd    = quote_is_double;
    w.pg    = pending_greater;
    w.wl    = word_length;
    w.cnt   = token_counter;

    // resolve a held '>' first
    if (w.pg) begin
      w.pg = 1'b0;
      if (c == scl_pkg::CH_GT) begin
        w    = emit(w, scl_pkg::KIND_APP);
        w    = count(w);
        take = 1'b0;
      end else begin
        w = emit(w, scl_pkg::KIND_ROUT);
        w = count(w);
      end
    end

    if (take) begin
      if (w.q) begin
        if (c == (w.qd ? scl_pkg::CH_DQ : scl_pkg::CH_SQ)) begin
          w.q = 1'b0;
        end else begin
          as_byte = 1'b1;
        end
      end else begin
        unique case (c) inside
          scl_pkg::CH_SP, scl_pkg::CH_TAB: begin
            cw = 1'b1;
          end
          scl_pkg::CH_DQ, scl_pkg::CH_SQ: begin
            w.iw = 1'b1;
            w.q  = 1'b1;
            w.qd = (c == scl_pkg::CH_DQ);
          end
          scl_pkg::CH_GT: begin
            cw   = 1'b1;
            w.pg = 1'b1;
          end
          scl_pkg::CH_LT: begin
            cw     = 1'b1;
            has_op = 1'b1;
            op     = scl_pkg::KIND_RIN;
          end
          scl_pkg::CH_BAR: begin
            cw     = 1'b1;
            has_op = 1'b1;
            op     = scl_pkg::KIND_PIPE;
          end
          default: begin
            as_byte = 1'b1;
          end
        endcase
      end
      if (cw) w = close_word(w);
      if (has_op) begin
        w = emit(w, op);
        w = count(w);
      end
      if (as_byte) begin
        w.iw = 1'b1;
        w    = emit(w, scl_pkg::KIND_BYTE);
        wb   = c;
        w.wl = w.wl + 1'b1;
        // split an overlong word
        if (w.wl >= scl_pkg::LEN_W'(MAX_WORD)) w = close_word(w);
      end
    end

    if (cmd.line_end) begin
      if (w.pg) begin
        w    = emit(w, scl_pkg::KIND_ROUT);
        w    = count(w);
        w.pg = 1'b0;
      end
      w     = close_word(w);
      w     = emit(w, scl_pkg::KIND_LEND);
      total = w.cnt;
    end
  end

  assign push                = accept && (w.n != '0);
  assign push_data.n         = w.n;
  assign push_data.kinds     = w.kinds;
  assign push_data.word_byte = wb;
  assign push_data.total     = total;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word         <= 1'b0;
      quoting         <= 1'b0;
      quote_is_double <= 1'b0;
      pending_greater <= 1'b0;
      word_length     <= '0;
      token_counter   <= '0;
    end else if (accept) begin
      if (cmd.line_end) begin
        in_word         <= 1'b0;
        quoting         <= 1'b0;
        quote_is_double <= 1'b0;
        pending_greater <= 1'b0;
        word_length     <= '0;
        token_counter   <= '0;
      end else begin
        in_word         <= w.iw;
        quoting         <= w.q;
        quote_is_double <= w.qd;
        pending_greater <= w.pg;
        word_length     <= w.wl;
        token_counter   <= w.cnt;
      end
    end
  end

`ifndef SYNTHESIS
  a_len_below_max: assert property (@(posedge clk) disable iff (rst)
    word_length < scl_pkg::LEN_W'(MAX_WORD))
    else $error("word length reached the split limit without closing");

  a_line_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.line_end) |=> (token_counter == '0 && !in_word && !pending_greater
                                  && !quoting))
    else $error("lexer state not cleared after line end");
`endif

endmodule

// ===== sv/scl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_queue
// Short queue of result bundles between the classifier and the emitter.
// ----------------------------------------------------------------------------
module scl_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  scl_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output scl_pkg::bundle_t head,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  scl_pkg::bundle_t  mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full  = (fill == FILL_W'(DEPTH));
  assign empty = (fill == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH) && !(pop && empty) && !(push && full))
    else $error("queue overrun or underrun");
`endif

endmodule

// ===== sv/scl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_back
// Walks each queued bundle and hands out its results one per cycle through
// an output register, holding while a result waits and tok.ready is low.
// ----------------------------------------------------------------------------
module scl_back (
  input  logic             clk,
  input  logic             rst,
  input  scl_pkg::bundle_t head,
  input  logic             empty,
  output logic             pop,
  scl_tok_if.source        tok
);

  logic                          res_valid;
  scl_pkg::kind_t                res_kind;
  logic [7:0]                    res_byte;
  logic [scl_pkg::CNT_W-1:0]     res_total;
  logic                          res_last;
  logic [scl_pkg::RES_IDX_W-1:0] idx;

  logic                          load;
  logic                          last;
  scl_pkg::kind_t                cur_kind;

  assign cur_kind = head.kinds[idx];
  assign last     = ({1'b0, idx} == head.n - 1'b1);
  assign load     = !empty && (!res_valid || tok.ready);
  assign pop      = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      res_valid <= 1'b1;
      idx       <= last ? '0 : idx + 1'b1;
    end else if (tok.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_kind  <= cur_kind;
      res_byte  <= (cur_kind == scl_pkg::KIND_BYTE) ? head.word_byte : 8'd0;
      res_total <= (cur_kind == scl_pkg::KIND_LEND) ? head.total : '0;
      res_last  <= last;
    end
  end

  assign tok.valid       = res_valid;
  assign tok.kind        = res_kind;
  assign tok.word_byte   = res_byte;
  assign tok.token_total = res_total;
  assign tok.last_of_run = res_last;

`ifndef SYNTHESIS
  a_bundle_size: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (head.n != '0 && head.n <= scl_pkg::RES_CNT_W'(scl_pkg::RES_MAX)))
    else $error("queued bundle has a bad result count");

  a_lend_closes: assert property (@(posedge clk) disable iff (rst)
    (tok.valid && tok.kind == scl_pkg::KIND_LEND) |-> tok.last_of_run)
    else $error("line end result not marked as last of run");
`endif

endmodule

// ===== sv/shell_command_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_command_lexer
// Streaming command line tokenizer: words, quotes, redirects and pipes.
// ----------------------------------------------------------------------------
//   channel  dir  payload                                       handshake
//   cmd      in   char_in[8], line_end                          valid/ready
//   tok      out  kind[3], word_byte[8], token_total[10],       valid/ready
//                 last_of_run
//
// A byte is classified in the cycle it is accepted; its results (0 to 4)
// leave one per cycle from the output register while tok.ready is high, so
// one byte per cycle is sustained while each byte yields at most one result.
// A byte with k results holds the emitter until all k have left; the QUEUE_DEPTH
// bundle queue absorbs that until it fills, then cmd.ready drops.
// Synchronous reset clears lexer state, queue and output.
// ----------------------------------------------------------------------------
module shell_command_lexer #(
  parameter int MAX_WORD    = 255,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  scl_cmd_if.sink    cmd,
  scl_tok_if.source  tok
);

  logic             push;
  scl_pkg::bundle_t push_data;
  logic             full;
  logic             pop;
  scl_pkg::bundle_t head;
  logic             empty;

  scl_front #(.MAX_WORD(MAX_WORD)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  scl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  scl_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .tok   (tok)
  );

endmodule
